@@ src/nad_pkg.sv @@
// ---------------------------------------------------------------------------
// nad_pkg: shared definitions for the nearest anchor distance block
// Widths, register indexes and reset values, the anchor angle table, and
// small arithmetic helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package nad_pkg;

   // anchor set
   localparam int TOTAL_ANCHORS = 21;
   localparam int ANCHOR_COUNT  = 21;
   localparam int USED_ANCHORS  = (ANCHOR_COUNT < 1) ? 1 :
                                  ((ANCHOR_COUNT > TOTAL_ANCHORS) ? TOTAL_ANCHORS : ANCHOR_COUNT);

   // field widths
   localparam int POS_W      = 17;
   localparam int RADIUS_W   = 16;
   localparam int CAP_W      = 17;
   localparam int DIST_W     = 18;
   localparam int TRIG_W     = 16;
   localparam int FRAC_BITS  = 15;
   localparam int ROUND_BIAS = 16384;

   // datapath widths
   localparam int COORD_W = 18;           // scaled anchor coordinate
   localparam int DIFF_W  = POS_W + 1;    // query minus anchor
   localparam int SQ_W    = 34;           // one squared difference
   localparam int SUM_W   = 36;           // squared distance
   localparam int ROOT_W  = SUM_W / 2;

   // square root pipeline
   localparam int SQRT_STEPS  = 3;        // result bits per stage
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

   // register port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_RADIUS  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIDDLE_RADIUS = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_RADIUS  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_CAP_HEIGHT    = CSR_INDEX_W'(3);

   localparam logic [RADIUS_W-1:0]     INNER_RADIUS_RESET  = RADIUS_W'(12800);
   localparam logic [RADIUS_W-1:0]     MIDDLE_RADIUS_RESET = RADIUS_W'(28960);
   localparam logic [RADIUS_W-1:0]     OUTER_RADIUS_RESET  = RADIUS_W'(44800);
   localparam logic signed [CAP_W-1:0] CAP_HEIGHT_RESET    = 17'sd53792;

   typedef enum logic [1:0] {
      RING_INNER,
      RING_MIDDLE,
      RING_OUTER
   } ring_type;

   typedef struct packed {
      ring_type                  ring;
      logic signed [TRIG_W-1:0]  cq;
      logic signed [TRIG_W-1:0]  sq;
   } anchor_type;

   // Q1.15 cosine / sine; inner, then middle, then outer, increasing angle
   localparam anchor_type ANCHOR_TAB [TOTAL_ANCHORS] = '{
      '{RING_INNER,   16'sd23170,  16'sd23170},
      '{RING_INNER,  -16'sd31652,  16'sd8481},
      '{RING_INNER,   16'sd8481,  -16'sd31652},
      '{RING_MIDDLE,  16'sd31652,  16'sd8481},
      '{RING_MIDDLE,  16'sd8481,   16'sd31652},
      '{RING_MIDDLE, -16'sd23170,  16'sd23170},
      '{RING_MIDDLE, -16'sd31652, -16'sd8481},
      '{RING_MIDDLE, -16'sd8481,  -16'sd31652},
      '{RING_MIDDLE,  16'sd23170, -16'sd23170},
      '{RING_OUTER,   16'sd32767,  16'sd0},
      '{RING_OUTER,   16'sd28378,  16'sd16384},
      '{RING_OUTER,   16'sd16384,  16'sd28378},
      '{RING_OUTER,   16'sd0,      16'sd32767},
      '{RING_OUTER,  -16'sd16384,  16'sd28378},
      '{RING_OUTER,  -16'sd28378,  16'sd16384},
      '{RING_OUTER,   16'sh8000,   16'sd0},
      '{RING_OUTER,  -16'sd28378, -16'sd16384},
      '{RING_OUTER,  -16'sd16384, -16'sd28378},
      '{RING_OUTER,   16'sd0,      16'sh8000},
      '{RING_OUTER,   16'sd16384, -16'sd28378},
      '{RING_OUTER,   16'sd28378, -16'sd16384}
   };

   // radius * Q1.15 factor, rounded half up (arithmetic shift is a floor)
   function automatic logic signed [COORD_W-1:0] scale_coord(
      input logic [RADIUS_W-1:0]     radius,
      input logic signed [TRIG_W-1:0] q
   );
      logic signed [RADIUS_W+TRIG_W:0] prod;
      prod = $signed({1'b0, radius}) * q + (RADIUS_W+TRIG_W+1)'(ROUND_BIAS);
      return prod[FRAC_BITS +: COORD_W];
   endfunction

   function automatic logic [SUM_W-1:0] min_d2(
      input logic [SUM_W-1:0] a,
      input logic [SUM_W-1:0] b
   );
      return (b < a) ? b : a;
   endfunction

endpackage

`default_nettype wire

@@ src/nad_isqrt.sv @@
// ---------------------------------------------------------------------------
// nad_isqrt: pipelined floor integer square root
// Restoring digit recurrence, SQRT_STEPS root bits per register stage.
// One word in per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module nad_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [nad_pkg::SUM_W-1:0]   in_radicand,
   output logic                        out_valid,
   output logic [nad_pkg::ROOT_W-1:0]  out_root
);
   import nad_pkg::*;

   localparam int REM_W = ROOT_W + 3;

   typedef struct packed {
      logic [SUM_W-1:0]  rad;    // radicand bits not yet consumed, MSB first
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_state_type;

   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s);
      sqrt_state_type   n;
      logic [REM_W-1:0] r2;
      logic [REM_W-1:0] trial;
      r2    = {s.rem[REM_W-3:0], s.rad[SUM_W-1 -: 2]};
      trial = REM_W'({s.root, 2'b01});
      n.rad = {s.rad[SUM_W-3:0], 2'b00};
      if (r2 >= trial) begin
         n.rem  = r2 - trial;
         n.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = r2;
         n.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

   sqrt_state_type state_ff [SQRT_STAGES];
   sqrt_state_type state_in [SQRT_STAGES];
   logic           valid_ff [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      always_comb begin
         sqrt_state_type cur;
         if (s == 0) begin
            cur.rad  = in_radicand;
            cur.rem  = '0;
            cur.root = '0;
         end else begin
            cur = state_ff[(s == 0) ? 0 : s-1];
         end
         for (int k = 0; k < SQRT_STEPS; k++) begin
            cur = sqrt_step(cur);
         end
         state_in[s] = cur;
      end

      always_ff @(posedge clock) begin
         state_ff[s] <= state_in[s];
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = state_ff[SQRT_STAGES-1].root;

   // floor root: remainder never exceeds twice the root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (state_ff[SQRT_STAGES-1].rem <= REM_W'({out_root, 1'b0})))
      else $error("isqrt remainder out of bound");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, SQRT_STAGES))
      else $error("isqrt word without matching input");

endmodule

`default_nettype wire

@@ src/nearest_anchor_distance.sv @@
// ---------------------------------------------------------------------------
// nearest_anchor_distance: distance from a 3D point to the nearest anchor
// Anchors sit on three rings in the plane z = cap height; the result is the
// floor Euclidean distance to the closest one, in 1/16 cm.
// ---------------------------------------------------------------------------
// Usage:
//  - Query word: req_pos_x/y/z, taken at a rising edge with start high and
//    busy low. busy is high only while reset is applied and in the cycle
//    after it, so a new word can be taken in every cycle.
//  - Result word: rsp_min_distance with strobe rsp_valid, high for exactly
//    one cycle per query, in query order. The receiver cannot stall; the
//    pipeline never holds anything back.
//  - Pipeline: a query passes 7 stages for anchor differences, squares, sums
//    and a registered minimum tree, then 6 stages of square root at 3 bits
//    per stage.
//  - Throughput: one word per cycle, set by the fully pipelined datapath.
//  - Registers: csr_valid/csr_ready with csr_index and csr_wdata; ring radii
//    and cap height. Write them while no query is in flight. Scaled anchor
//    coordinates are registered from them in the cycle after a write.
//  - Reset (synchronous) restores register defaults and drops all words in
//    flight.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_anchor_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [nad_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [nad_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [nad_pkg::POS_W-1:0]    req_pos_z,
   output logic                                rsp_valid,
   output logic [nad_pkg::DIST_W-1:0]          rsp_min_distance,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nad_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nad_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import nad_pkg::*;

   localparam int N0 = USED_ANCHORS;
   localparam int N1 = (N0 + 1) / 2;
   localparam int N2 = (N1 + 1) / 2;
   localparam int N3 = (N2 + 1) / 2;
   localparam int N4 = (N3 + 1) / 2;
   localparam int PIPE_DEPTH = 7 + SQRT_STAGES;

   logic busy_ff;
   logic req_accept;

   // configuration
   logic [RADIUS_W-1:0]     inner_radius_ff;
   logic [RADIUS_W-1:0]     middle_radius_ff;
   logic [RADIUS_W-1:0]     outer_radius_ff;
   logic signed [CAP_W-1:0] cap_ff;

   logic signed [COORD_W-1:0] anchor_x_in [N0];
   logic signed [COORD_W-1:0] anchor_y_in [N0];
   logic signed [COORD_W-1:0] anchor_x_ff [N0];
   logic signed [COORD_W-1:0] anchor_y_ff [N0];

   // pipeline
   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [POS_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [DIFF_W-1:0] dx_ff [N0];
   logic signed [DIFF_W-1:0] dy_ff [N0];
   logic signed [DIFF_W-1:0] dz_ff;
   logic [SQ_W-1:0]          sqx_ff [N0];
   logic [SQ_W-1:0]          sqy_ff [N0];
   logic [SQ_W-1:0]          sqz_ff;
   logic [SUM_W-1:0]         sum_ff [N0];
   logic [SUM_W-1:0]         lvl1 [N1];
   logic [SUM_W-1:0]         tree_a_in [N2];
   logic [SUM_W-1:0]         tree_a_ff [N2];
   logic [SUM_W-1:0]         lvl3 [N3];
   logic [SUM_W-1:0]         tree_b_in [N4];
   logic [SUM_W-1:0]         tree_b_ff [N4];
   logic [SUM_W-1:0]         min_in;
   logic [SUM_W-1:0]         min_ff;
   logic signed [2*DIFF_W-1:0] sqz_full;

   assign busy       = busy_ff;
   assign csr_ready  = ~busy_ff;
   assign req_accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_radius_ff  <= INNER_RADIUS_RESET;
         middle_radius_ff <= MIDDLE_RADIUS_RESET;
         outer_radius_ff  <= OUTER_RADIUS_RESET;
         cap_ff           <= CAP_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INNER_RADIUS:  inner_radius_ff  <= csr_wdata[RADIUS_W-1:0];
            CSR_MIDDLE_RADIUS: middle_radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_OUTER_RADIUS:  outer_radius_ff  <= csr_wdata[RADIUS_W-1:0];
            CSR_CAP_HEIGHT:    cap_ff           <= $signed(csr_wdata[CAP_W-1:0]);
            default: ;
         endcase
      end
   end

   // per-anchor lanes: scaled coordinates, differences, squares, sums
   for (genvar i = 0; i < N0; i++) begin : g_lane
      logic [RADIUS_W-1:0]        lane_radius;
      logic signed [2*DIFF_W-1:0] sqx_full;
      logic signed [2*DIFF_W-1:0] sqy_full;

      always_comb begin
         unique case (ANCHOR_TAB[i].ring)
            RING_INNER:  lane_radius = inner_radius_ff;
            RING_MIDDLE: lane_radius = middle_radius_ff;
            default:     lane_radius = outer_radius_ff;
         endcase
         anchor_x_in[i] = scale_coord(lane_radius, ANCHOR_TAB[i].cq);
         anchor_y_in[i] = scale_coord(lane_radius, ANCHOR_TAB[i].sq);
      end

      assign sqx_full = dx_ff[i] * dx_ff[i];
      assign sqy_full = dy_ff[i] * dy_ff[i];

      always_ff @(posedge clock) begin
         anchor_x_ff[i] <= anchor_x_in[i];
         anchor_y_ff[i] <= anchor_y_in[i];
         dx_ff[i]       <= {px_ff[POS_W-1], px_ff} - anchor_x_ff[i];
         dy_ff[i]       <= {py_ff[POS_W-1], py_ff} - anchor_y_ff[i];
         sqx_ff[i]      <= sqx_full[SQ_W-1:0];
         sqy_ff[i]      <= sqy_full[SQ_W-1:0];
         sum_ff[i]      <= SUM_W'(sqx_ff[i]) + SUM_W'(sqy_ff[i]) + SUM_W'(sqz_ff);
      end
   end

   assign sqz_full = dz_ff * dz_ff;

   // minimum tree, two compare levels per register stage and one before min_ff
   for (genvar i = 0; i < N1; i++) begin : g_l1
      if (2*i+1 < N0) begin : g_pair
         assign lvl1[i] = min_d2(sum_ff[2*i], sum_ff[2*i+1]);
      end else begin : g_pass
         assign lvl1[i] = sum_ff[2*i];
      end
   end
   for (genvar i = 0; i < N2; i++) begin : g_l2
      if (2*i+1 < N1) begin : g_pair
         assign tree_a_in[i] = min_d2(lvl1[2*i], lvl1[2*i+1]);
      end else begin : g_pass
         assign tree_a_in[i] = lvl1[2*i];
      end
   end
   for (genvar i = 0; i < N3; i++) begin : g_l3
      if (2*i+1 < N2) begin : g_pair
         assign lvl3[i] = min_d2(tree_a_ff[2*i], tree_a_ff[2*i+1]);
      end else begin : g_pass
         assign lvl3[i] = tree_a_ff[2*i];
      end
   end
   for (genvar i = 0; i < N4; i++) begin : g_l4
      if (2*i+1 < N3) begin : g_pair
         assign tree_b_in[i] = min_d2(lvl3[2*i], lvl3[2*i+1]);
      end else begin : g_pass
         assign tree_b_in[i] = lvl3[2*i];
      end
   end
   if (N4 > 1) begin : g_l5_pair
      assign min_in = min_d2(tree_b_ff[0], tree_b_ff[N4-1]);
   end else begin : g_l5_pass
      assign min_in = tree_b_ff[0];
   end

   always_ff @(posedge clock) begin
      px_ff     <= req_pos_x;
      py_ff     <= req_pos_y;
      pz_ff     <= req_pos_z;
      dz_ff     <= {pz_ff[POS_W-1], pz_ff} - {cap_ff[CAP_W-1], cap_ff};
      sqz_ff    <= sqz_full[SQ_W-1:0];
      tree_a_ff <= tree_a_in;
      tree_b_ff <= tree_b_in;
      min_ff    <= min_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= req_accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   nad_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v7_ff),
      .in_radicand (min_ff),
      .out_valid   (rsp_valid),
      .out_root    (rsp_min_distance)
   );

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, PIPE_DEPTH))
      else $error("result word without a matching query");

   a_min_bound: assert property (@(posedge clock) disable iff (reset)
      v7_ff |-> (min_ff <= $past(sum_ff[0], 3)))
      else $error("minimum exceeds first anchor distance");

   a_cap_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == CSR_CAP_HEIGHT))
      |=> (cap_ff == $signed($past(csr_wdata[CAP_W-1:0]))))
      else $error("cap height write lost");

endmodule

`default_nettype wire

@@ sim/tb_nearest_anchor_distance.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_anchor_distance: self-checking bench for nearest_anchor_distance
// Query words go in through start/busy and each result strobe is checked
// against a distance predictor built into the bench. The run covers extreme
// points, exact anchor hits and near misses, and fully random points. It
// steps through several ring radius and cap height settings, including
// zero radii and all-maximum ones. The sender's idle rate changes by phase.
// ----------------------------------------------------------------------------

module tb_nearest_anchor_distance;
   timeunit 1ns;
   timeprecision 1ps;

   import nad_pkg::*;

   localparam int     ANCHORS       = 21;
   localparam int     INNER_END     = 3;
   localparam int     MIDDLE_END    = 9;
   localparam int     PHASES        = 6;
   localparam int     RANDOM_PER_PH = 300;
   localparam int     DRAIN_CYCLES  = 40;
   localparam int     CYCLE_LIMIT   = 100000;
   localparam longint POS_MAX       = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_MIN       = -(longint'(1) << (POS_W - 1));

   // indexes past the last register; writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LAST  = '1;

   // Q1.15 cosine / sine: inner ring, then middle, then outer
   localparam int ANCHOR_COS [ANCHORS] = '{
       23170, -31652,   8481,
       31652,   8481, -23170, -31652,  -8481,  23170,
       32767,  28378,  16384,      0, -16384, -28378,
      -32768, -28378, -16384,      0,  16384,  28378
   };
   localparam int ANCHOR_SIN [ANCHORS] = '{
       23170,   8481, -31652,
        8481,  31652,  23170,  -8481, -31652, -23170,
           0,  16384,  28378,  32767,  28378,  16384,
           0, -16384, -28378, -32768, -28378, -16384
   };

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } query_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      longint            stamp;
   } distance_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    start     = 1'b0;
   logic                    busy;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic                    rsp_valid;
   logic [DIST_W-1:0]       rsp_min_distance;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // bench copy of the register file
   logic [RADIUS_W-1:0]     inner_radius  = INNER_RADIUS_RESET;
   logic [RADIUS_W-1:0]     middle_radius = MIDDLE_RADIUS_RESET;
   logic [RADIUS_W-1:0]     outer_radius  = OUTER_RADIUS_RESET;
   logic signed [CAP_W-1:0] cap_height    = CAP_HEIGHT_RESET;

   query_type    query_backlog [$];
   distance_type pending_distances [$];

   int send_idle_pct = 10;
   int error_count   = 0;
   int words_checked = 0;
   int reg_writes    = 0;
   int cycle_count   = 0;

   nearest_anchor_distance uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_valid        (rsp_valid),
      .rsp_min_distance (rsp_min_distance),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---- distance predictor ------------------------------------------------

   function automatic logic [RADIUS_W-1:0] ring_radius(input int k);
      if (k < INNER_END) return inner_radius;
      if (k < MIDDLE_END) return middle_radius;
      return outer_radius;
   endfunction

   // radius * Q1.15, rounded half up; >>> on a signed value floors
   function automatic longint anchor_coord(input logic [RADIUS_W-1:0] radius, input int q);
      longint p;
      p = longint'(radius) * longint'(q) + 16384;
      return p >>> 15;
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = longint'(1) << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    -= root + probe;
            root  = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic logic [DIST_W-1:0] nearest_dist(input logic signed [POS_W-1:0] px,
                                                      input logic signed [POS_W-1:0] py,
                                                      input logic signed [POS_W-1:0] pz);
      longint dx;
      longint dy;
      longint dz;
      longint d2;
      longint best;
      best = 0;
      dz   = longint'(pz) - longint'(cap_height);
      for (int k = 0; k < USED_ANCHORS; k++) begin
         dx = longint'(px) - anchor_coord(ring_radius(k), ANCHOR_COS[k]);
         dy = longint'(py) - anchor_coord(ring_radius(k), ANCHOR_SIN[k]);
         d2 = dx * dx + dy * dy + dz * dz;
         if (k == 0 || d2 < best) best = d2;
      end
      return DIST_W'(floor_root(longint'(best)));
   endfunction

   // ---- stimulus helpers --------------------------------------------------

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
      if (v > POS_MAX) return POS_W'(POS_MAX);
      if (v < POS_MIN) return POS_W'(POS_MIN);
      return POS_W'(v);
   endfunction

   function automatic query_type anchor_point(input int k, input longint dx, input longint dy,
                                              input longint dz);
      query_type q;
      q.x = clamp_pos(anchor_coord(ring_radius(k), ANCHOR_COS[k]) + dx);
      q.y = clamp_pos(anchor_coord(ring_radius(k), ANCHOR_SIN[k]) + dy);
      q.z = clamp_pos(longint'(cap_height) + dz);
      return q;
   endfunction

   function automatic longint jitter(input int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   function automatic query_type random_query();
      query_type q;
      int        pick;
      longint    reach;
      pick  = $urandom_range(9);
      reach = longint'(outer_radius) + 64;
      if (pick < 4) begin
         q.x = POS_W'($urandom);
         q.y = POS_W'($urandom);
         q.z = POS_W'($urandom);
      end else if (pick == 4) begin
         q = anchor_point($urandom_range(ANCHORS - 1), 0, 0, 0);
      end else if (pick < 7) begin
         q = anchor_point($urandom_range(ANCHORS - 1), jitter(32), jitter(32), jitter(32));
      end else begin
         // somewhere over the ring disk, close to the anchor plane
         q.x = clamp_pos(longint'($urandom_range(32'(2 * reach))) - reach);
         q.y = clamp_pos(longint'($urandom_range(32'(2 * reach))) - reach);
         q.z = clamp_pos(longint'(cap_height) + jitter(4096));
      end
      return q;
   endfunction

   task automatic queue_query(input query_type q);
      query_backlog.insert(query_backlog.size(), q);
   endtask

   task automatic queue_corners();
      query_type q;
      for (int c = 0; c < 8; c++) begin
         q.x = c[0] ? POS_W'(POS_MAX) : POS_W'(POS_MIN);
         q.y = c[1] ? POS_W'(POS_MAX) : POS_W'(POS_MIN);
         q.z = c[2] ? POS_W'(POS_MAX) : POS_W'(POS_MIN);
         queue_query(q);
      end
      q = '{x: '0, y: '0, z: '0};
      queue_query(q);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  wdata);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
      unique case (index)
         CSR_INNER_RADIUS:  inner_radius  = wdata[RADIUS_W-1:0];
         CSR_MIDDLE_RADIUS: middle_radius = wdata[RADIUS_W-1:0];
         CSR_OUTER_RADIUS:  outer_radius  = wdata[RADIUS_W-1:0];
         CSR_CAP_HEIGHT:    cap_height    = wdata;
         default: ;
      endcase
   endtask

   // top bit of a radius write is junk that the block must drop
   task automatic set_rings(input logic [RADIUS_W-1:0] inner, input logic [RADIUS_W-1:0] middle,
                            input logic [RADIUS_W-1:0] outer, input logic [CAP_W-1:0] cap);
      csr_write(CSR_INNER_RADIUS, {1'($urandom), inner});
      csr_write(CSR_MIDDLE_RADIUS, {1'($urandom), middle});
      csr_write(CSR_OUTER_RADIUS, {1'($urandom), outer});
      csr_write(CSR_CAP_HEIGHT, cap);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (query_backlog.size() != 0 || start || pending_distances.size() != 0);
   endtask

   // ---- driver ------------------------------------------------------------

   always @(posedge clock) begin : driver
      query_type next_query;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pending_distances.insert(pending_distances.size(),
               '{distance: nearest_dist(req_pos_x, req_pos_y, req_pos_z), stamp: $time});
         end
         if (!start || !busy) begin
            if (query_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_query = query_backlog.pop_front();
               start     <= 1'b1;
               req_pos_x <= next_query.x;
               req_pos_y <= next_query.y;
               req_pos_z <= next_query.z;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---- monitor -----------------------------------------------------------

   always @(posedge clock) begin : monitor
      distance_type want;
      if (!reset && rsp_valid) begin
         // an expectation stamped this edge cannot be the one answered here
         if (pending_distances.size() == 0 || pending_distances[0].stamp >= $time) begin
            error_count++;
            $display("%0t: stray result word, expected none, got %0d", $time, rsp_min_distance);
         end else begin
            want = pending_distances.pop_front();
            words_checked++;
            if (rsp_min_distance !== want.distance) begin
               error_count++;
               $display("%0t: min_distance mismatch, expected %0d, got %0d",
                        $time, want.distance, rsp_min_distance);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result words outstanding", $time,
                  pending_distances.size());
         $display("tb_nearest_anchor_distance: errors");
         $finish;
      end
   end

   // ---- sequence ----------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         send_idle_pct = (ph < 2) ? 10 : ((ph < 4) ? 58 : 0);
         unique case (ph)
            0: ;  // reset defaults
            1: set_rings('0, '0, '0, CAP_W'(POS_MIN));  // every anchor on the z axis
            2: set_rings('1, '1, '1, CAP_W'(POS_MAX));
            3: begin
               set_rings(RADIUS_W'($urandom), RADIUS_W'($urandom), RADIUS_W'($urandom),
                         CAP_W'($urandom));
               csr_write(CSR_INDEX_SPARE, CSR_DATA_W'($urandom));
               csr_write(CSR_INDEX_LAST, CSR_DATA_W'($urandom));
            end
            4: set_rings(RADIUS_W'($urandom), RADIUS_W'($urandom), RADIUS_W'($urandom),
                         CAP_W'($urandom));
            default: set_rings(RADIUS_W'(1), '1, '0, '0);
         endcase

         queue_corners();
         if (ph == 0) begin
            queue_query('{x: -1, y: 1, z: -1});
            for (int k = 0; k < ANCHORS; k++) begin
               if (k % 3 == 0 || k < INNER_END) queue_query(anchor_point(k, 0, 0, 0));
            end
            queue_query(anchor_point(0, 1, -1, 1));
            queue_query('{x: 0, y: 0, z: cap_height});  // ties on the inner ring
         end
         repeat (RANDOM_PER_PH) queue_query(random_query());
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d result words across %0d register settings (%0d register writes)",
               words_checked, PHASES, reg_writes);
      if (error_count == 0) begin
         $display("tb_nearest_anchor_distance: clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_nearest_anchor_distance: errors");
      end
      $finish;
   end

endmodule
